@@ design/assert_macros.svh @@
// shared assertion macros, clocked on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ design/fasb_pkg.sv @@
`default_nettype none

package fasb_pkg;

  // register and field widths, and the number of ranges
  localparam int unsigned RegW      = 40;
  localparam int unsigned NumRanges = 3;
  localparam int unsigned PaddrW    = 6;
  localparam int unsigned PdataW    = 64;

  // defaults for the top-level parameters
  localparam int unsigned FreeDepthDef = 1024;
  localparam int unsigned FrameBitsDef = 40;

  typedef enum logic {
    CmdAlloc = 1'b0,
    CmdFree  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StatStack = 2'd0,
    StatRange = 2'd1,
    StatNone  = 2'd2,
    StatFreed = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RegR0First = 3'd0,
    RegR0Count = 3'd1,
    RegR1First = 3'd2,
    RegR1Count = 3'd3,
    RegR2First = 3'd4,
    RegR2Count = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic            cmd;
    logic [RegW-1:0] returned_frame;
  } in_beat_t;

  typedef struct packed {
    logic [RegW-1:0] granted_frame;
    status_e         status;
  } out_beat_t;

  typedef struct packed {
    logic [NumRanges-1:0][RegW-1:0] first;
    logic [NumRanges-1:0][RegW-1:0] count;
  } range_cfg_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

endpackage

`default_nettype wire

@@ design/fasb_ram.sv @@
`default_nettype none

module fasb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ design/fasb_regs.sv @@
`default_nettype none

module fasb_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fasb_pkg::PaddrW-1:0] paddr,
  input  wire logic [fasb_pkg::PdataW-1:0] pwdata,
  output logic      [fasb_pkg::PdataW-1:0] prdata,
  output logic                             pready,
  output fasb_pkg::range_cfg_t             cfg_o
);

  import fasb_pkg::*;

  range_cfg_t cfg_q, cfg_d;
  reg_idx_e   idx;
  logic       wr_en;

  // 8-byte register slots
  assign idx    = reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegR0First: cfg_d.first[0] = pwdata[RegW-1:0];
        RegR0Count: cfg_d.count[0] = pwdata[RegW-1:0];
        RegR1First: cfg_d.first[1] = pwdata[RegW-1:0];
        RegR1Count: cfg_d.count[1] = pwdata[RegW-1:0];
        RegR2First: cfg_d.first[2] = pwdata[RegW-1:0];
        RegR2Count: cfg_d.count[2] = pwdata[RegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegR0First: prdata = PdataW'(cfg_q.first[0]);
      RegR0Count: prdata = PdataW'(cfg_q.count[0]);
      RegR1First: prdata = PdataW'(cfg_q.first[1]);
      RegR1Count: prdata = PdataW'(cfg_q.count[1]);
      RegR2First: prdata = PdataW'(cfg_q.first[2]);
      RegR2Count: prdata = PdataW'(cfg_q.count[2]);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ design/fasb_stack.sv @@
`default_nettype none
`include "assert_macros.svh"

module fasb_stack #(
  parameter int unsigned Depth = fasb_pkg::FreeDepthDef,
  parameter int unsigned Width = fasb_pkg::FrameBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fasb_pkg::stk_req_t req_i,
  input  wire logic [Width-1:0]   push_data_i,
  output fasb_pkg::stk_stat_t     stat_o,
  output logic      [Width-1:0]   top_o
);

  import fasb_pkg::*;

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [CntW-1:0]  count_q, count_d;
  logic [Width-1:0] top_q, top_d;
  logic [Width-1:0] sec_q, sec_d;
  logic             sec_reg_q, sec_reg_d;
  logic [Width-1:0] second;
  logic [Width-1:0] ram_rdata;
  logic             ram_we;
  logic [CntW-1:0]  wr_ptr;
  logic [CntW-1:0]  rd_ptr;

  // top entry lives in top_q, the ram holds everything below it; the entry
  // just under the top comes either from sec_q or from the prefetched read
  assign second = sec_reg_q ? sec_q : ram_rdata;

  always_comb begin
    count_d   = count_q;
    top_d     = top_q;
    sec_d     = second;
    sec_reg_d = 1'b1;
    ram_we    = 1'b0;
    wr_ptr    = count_q - CntW'(1);
    rd_ptr    = count_q - CntW'(2);
    if (req_i.push) begin
      // old top sinks into the ram and becomes the second entry
      ram_we  = (count_q != '0);
      top_d   = push_data_i;
      sec_d   = top_q;
      count_d = count_q + CntW'(1);
    end else if (req_i.pop) begin
      // fetch the entry that will sit under the new top
      top_d     = second;
      sec_reg_d = 1'b0;
      rd_ptr    = count_q - CntW'(3);
      count_d   = count_q - CntW'(1);
    end
  end

  fasb_ram #(
    .Width (Width),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr[AddrW-1:0]),
    .wdata_i (top_q),
    .raddr_i (rd_ptr[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sec_reg_q <= 1'b1;
    end else begin
      count_q   <= count_d;
      sec_reg_q <= sec_reg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    sec_q <= sec_d;
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(Depth));
  assign top_o        = top_q;

  `ASSERT_NEVER(a_no_push_full, req_i.push && stat_o.full, "push into full stack")
  `ASSERT_NEVER(a_no_pop_empty, req_i.pop && stat_o.empty, "pop from empty stack")
  `ASSERT_AT(a_pop_drops, (req_i.pop |=> (count_q == $past(count_q) - CntW'(1))), "pop count")

endmodule

`default_nettype wire

@@ design/fasb_range.sv @@
`default_nettype none
`include "assert_macros.svh"

module fasb_range #(
  parameter int unsigned FrameBits = fasb_pkg::FrameBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fasb_pkg::range_cfg_t cfg_i,
  input  wire logic                 step_i,
  output logic                      avail_o,
  output logic [FrameBits-1:0]      frame_o
);

  import fasb_pkg::*;

  localparam logic [1:0] IdxSpent = 2'd3;

  logic [1:0]      ri_q, ri_d;
  logic [RegW-1:0] used_q, used_d;
  logic [RegW-1:0] cur_cnt;
  logic            cur_ok;
  logic [2:0]      cand;
  logic [1:0]      sel;
  logic [RegW-1:0] sel_first;
  logic [RegW-1:0] sel_cnt;
  logic [RegW-1:0] sel_used;
  logic [RegW-1:0] sum;
  logic [RegW-1:0] next_used;

  always_comb begin
    case (ri_q)
      2'd0:    cur_cnt = cfg_i.count[0];
      2'd1:    cur_cnt = cfg_i.count[1];
      2'd2:    cur_cnt = cfg_i.count[2];
      default: cur_cnt = '0;
    endcase
  end

  // current range still has frames left
  assign cur_ok = (used_q < cur_cnt);

  // a later range qualifies when it is not empty, the current one when not used up
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cand[j] = ((ri_q == 2'(j)) && cur_ok) ||
                ((ri_q < 2'(j)) && (cfg_i.count[j] != '0));
    end
  end

  assign avail_o = |cand;

  always_comb begin
    if (cand[0]) begin
      sel = 2'd0;
    end else if (cand[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  always_comb begin
    case (sel)
      2'd0: begin
        sel_first = cfg_i.first[0];
        sel_cnt   = cfg_i.count[0];
      end
      2'd1: begin
        sel_first = cfg_i.first[1];
        sel_cnt   = cfg_i.count[1];
      end
      default: begin
        sel_first = cfg_i.first[2];
        sel_cnt   = cfg_i.count[2];
      end
    endcase
  end

  assign sel_used  = (sel == ri_q) ? used_q : '0;
  assign sum       = sel_first + sel_used;
  assign next_used = sel_used + RegW'(1);
  assign frame_o   = sum[FrameBits-1:0];

  always_comb begin
    ri_d   = ri_q;
    used_d = used_q;
    if (step_i) begin
      if (!avail_o) begin
        ri_d   = IdxSpent;
        used_d = '0;
      end else if (next_used >= sel_cnt) begin
        ri_d   = sel + 2'd1;
        used_d = '0;
      end else begin
        ri_d   = sel;
        used_d = next_used;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ri_q   <= '0;
      used_q <= '0;
    end else begin
      ri_q   <= ri_d;
      used_q <= used_d;
    end
  end

  `ASSERT_AT(a_spent_clean, ((ri_q == IdxSpent) |-> (used_q == '0)), "spent with count")
  `ASSERT_AT(a_dry_spent, ((step_i && !avail_o) |=> (ri_q == IdxSpent)), "dry step not spent")

endmodule

`default_nettype wire

@@ design/frame_allocator_stack_bump_top.sv @@
// a request beat is captured in the input register and its result beat in the result register
// throughput: one request per cycle unless the result channel stalls, set by the stack top
//   register loop and the range compare and add between the input and result registers
// reset: asynchronous, clears the stack count, range position, range registers and
//   handshake state at once; the stack ram is not cleared and no sweep runs
`default_nettype none
`include "assert_macros.svh"

module frame_allocator_stack_bump_top #(
  parameter int unsigned FREE_DEPTH        = fasb_pkg::FreeDepthDef,
  parameter int unsigned FRAME_NUMBER_BITS = fasb_pkg::FrameBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // request channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire fasb_pkg::in_beat_t          in_data_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output fasb_pkg::out_beat_t              out_data_o,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fasb_pkg::PaddrW-1:0] paddr,
  input  wire logic [fasb_pkg::PdataW-1:0] pwdata,
  output logic      [fasb_pkg::PdataW-1:0] prdata,
  output logic                             pready
);

  import fasb_pkg::*;

  // frame numbers are kept to the narrower of the register and frame widths
  localparam int unsigned FrameBits =
    (FRAME_NUMBER_BITS < RegW) ? FRAME_NUMBER_BITS : RegW;

  range_cfg_t cfg;

  // input register
  logic     in_vld_q, in_vld_d;
  in_beat_t in_q;

  // result register
  logic      out_vld_q, out_vld_d;
  out_beat_t out_q, out_d;

  logic                 proc;
  logic                 is_free;
  stk_req_t             stk_req;
  stk_stat_t            stk_stat;
  logic [FrameBits-1:0] stk_top;
  logic                 rng_step;
  logic                 rng_avail;
  logic [FrameBits-1:0] rng_frame;
  logic                 no_grant;
  logic                 grant_nz;

  fasb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the held request is worked on when the result register is free or draining
  assign proc       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || proc;
  assign is_free    = (in_q.cmd == CmdFree);

  // free pushes unless full, allocate pops first and falls back to the ranges
  assign stk_req.push = proc && is_free && !stk_stat.full;
  assign stk_req.pop  = proc && !is_free && !stk_stat.empty;
  assign rng_step     = proc && !is_free && stk_stat.empty;

  fasb_stack #(
    .Depth (FREE_DEPTH),
    .Width (FrameBits)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (stk_req),
    .push_data_i (in_q.returned_frame[FrameBits-1:0]),
    .stat_o      (stk_stat),
    .top_o       (stk_top)
  );

  fasb_range #(
    .FrameBits (FrameBits)
  ) u_range (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .step_i  (rng_step),
    .avail_o (rng_avail),
    .frame_o (rng_frame)
  );

  // result beat for the request being worked on
  always_comb begin
    out_d.granted_frame = '0;
    out_d.status        = StatNone;
    if (is_free) begin
      if (!stk_stat.full) begin
        out_d.status = StatFreed;
      end
    end else if (!stk_stat.empty) begin
      out_d.granted_frame = RegW'(stk_top);
      out_d.status        = StatStack;
    end else if (rng_avail) begin
      out_d.granted_frame = RegW'(rng_frame);
      out_d.status        = StatRange;
    end
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready_o) begin
      in_vld_d = in_valid_i;
    end
    out_vld_d = out_vld_q;
    if (proc) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // the input payload loads only on a request beat, the result payload only when a request is worked on
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (proc) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign no_grant = (out_data_o.status == StatNone) || (out_data_o.status == StatFreed);
  assign grant_nz = (out_data_o.granted_frame != '0);

  // nothing granted means a zero frame number
  `ASSERT_NEVER(a_zero_grant, out_valid_o && no_grant && grant_nz, "nonzero frame without grant")
  // stack and range never serve the same request
  `ASSERT_NEVER(a_one_source, stk_req.pop && rng_step, "stack and range both stepped")

endmodule

`default_nettype wire
